// ===== rtl/core/max_priority_queue_top_assert.svh =====
// Assertion macros used by the checker file mpq_checker.sv.
`ifndef MAX_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mpq_pkg.sv =====
package mpq_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int ENTRY_W = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POLL   = 1'b1
  } op_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } cell_data_t;

  typedef struct packed {
    logic                      ins;
    logic                      pol;
    logic signed [VALUE_W-1:0] new_value;
    logic signed [PRIO_W-1:0]  new_prio;
  } cell_ctrl_t;

  localparam cell_data_t EMPTY_CELL = '{valid: 1'b0, value: '0, prio: '0};

endpackage

// ===== rtl/core/mpq_if.sv =====
interface mpq_req_if;
  import mpq_pkg::*;

  logic                      valid;
  logic                      ready;
  op_t                       opcode;
  logic signed [VALUE_W-1:0] item_value;
  logic signed [PRIO_W-1:0]  item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface mpq_rsp_if;
  import mpq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic                      was_empty;
  logic                      was_full;
  logic [ENTRY_W-1:0]        entry_count;

  modport source (output valid, out_value, was_empty, was_full, entry_count, input ready);
  modport sink (input valid, out_value, was_empty, was_full, entry_count, output ready);
endinterface

// ===== rtl/core/mpq_cell.sv =====
module mpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  mpq_pkg::cell_ctrl_t ctrl,
  input  mpq_pkg::cell_data_t prev,
  input  logic               prev_behind,
  input  mpq_pkg::cell_data_t next,
  output mpq_pkg::cell_data_t data,
  output logic               behind
);
  import mpq_pkg::*;

  logic                      valid;
  logic signed [VALUE_W-1:0] value;
  logic signed [PRIO_W-1:0]  prio;
  cell_data_t                data_next;

  assign data   = '{valid: valid, value: value, prio: prio};
  assign behind = valid && (prio >= ctrl.new_prio);

  // An insert keeps every entry of greater or equal priority in place and
  // moves the rest one cell back; a poll moves every entry one cell forward.
  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (!behind) begin
        if (prev_behind) begin
          data_next = '{valid: 1'b1, value: ctrl.new_value, prio: ctrl.new_prio};
        end else begin
          data_next = prev;
        end
      end
    end else if (ctrl.pol) begin
      data_next = next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= data_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= data_next.value;
    prio  <= data_next.prio;
  end

endmodule

// ===== rtl/core/max_priority_queue_top.sv =====
// Sorted max-priority queue of DEPTH entries, each a 32-bit value and a
// 16-bit signed priority, built as a row of cells kept in service order.
// The req channel carries one word per operation: an insert of item_value
// with item_priority, or a poll of the front entry. The rsp channel returns
// exactly one word per operation: the polled value (all ones on an insert
// or on a poll of an empty queue), the empty and full flags, and the number
// of entries held afterward. Entries of equal priority leave in the order
// in which they arrived, and an insert into a full queue is dropped.
// Every cell compares its priority with the incoming one in parallel and
// either keeps its entry or takes its neighbor's, so each operation is
// applied when it is accepted: the response is registered, shows in the
// next cycle, and one word can be taken every cycle. The single response
// register sets the rate; while it holds a word that the receiver has not
// taken, req is not ready. Reset empties the queue and response register.
module max_priority_queue_top (
  input logic    clk,
  input logic    rst,
  mpq_req_if.sink   req,
  mpq_rsp_if.source rsp
);
  import mpq_pkg::*;

  localparam int EXT_W = CNT_W + ENTRY_W;

  cell_data_t                data [DEPTH];
  logic                      behind [DEPTH];
  cell_ctrl_t                ctrl;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [EXT_W-1:0]          count_ext;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      was_empty;
  logic                      was_full;
  logic [ENTRY_W-1:0]        entry_count;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_full   = data[DEPTH-1].valid;
  assign is_empty  = !data[0].valid;

  assign ctrl.ins       = accept && (req.opcode == OP_INSERT) && !is_full;
  assign ctrl.pol       = accept && (req.opcode == OP_POLL) && !is_empty;
  assign ctrl.new_value = req.item_value;
  assign ctrl.new_prio  = req.item_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t prev_data;
    cell_data_t next_data;
    logic       prev_beh;

    if (i == 0) begin : g_first
      assign prev_data = EMPTY_CELL;
      assign prev_beh  = 1'b1;
    end else begin : g_mid
      assign prev_data = data[i-1];
      assign prev_beh  = behind[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = EMPTY_CELL;
    end else begin : g_inner
      assign next_data = data[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .prev        (prev_data),
      .prev_behind (prev_beh),
      .next        (next_data),
      .data        (data[i]),
      .behind      (behind[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pol) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign count_ext = EXT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value   <= ctrl.pol ? data[0].value : '1;
      was_empty   <= (req.opcode == OP_POLL) && is_empty;
      was_full    <= (req.opcode == OP_INSERT) && is_full;
      entry_count <= count_ext[ENTRY_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.out_value   = out_value;
  assign rsp.was_empty   = was_empty;
  assign rsp.was_full    = was_full;
  assign rsp.entry_count = entry_count;

endmodule

// ===== rtl/core/mpq_checker.sv =====
`include "max_priority_queue_top_assert.svh"

module mpq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [mpq_pkg::VALUE_W-1:0] out_value,
  input logic                               was_empty,
  input logic                               was_full,
  input logic [mpq_pkg::ENTRY_W-1:0]        entry_count
);
  import mpq_pkg::*;

  localparam logic [ENTRY_W-1:0] DEPTH_MOD = ENTRY_W'(DEPTH);

  logic                           stalled;
  logic                           req_take;
  logic                           empty_ok;
  logic                           full_ok;
  logic [VALUE_W+ENTRY_W+1:0]     rsp_word;

  assign stalled  = rsp_valid && !rsp_ready;
  assign req_take = req_valid && req_ready;
  assign empty_ok = (out_value == '1) && (entry_count == '0) && !was_full;
  assign full_ok  = (out_value == '1) && (entry_count == DEPTH_MOD) && !was_empty;
  assign rsp_word = {out_value, was_empty, was_full, entry_count};

  `MPQ_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_word), "stalled word changed")
  `MPQ_ASSERT_NOW(a_no_accept_on_stall, stalled, !req_take, "input taken while stalled")
  `MPQ_ASSERT_NOW(a_empty_word, rsp_valid && was_empty, empty_ok, "empty poll word malformed")
  `MPQ_ASSERT_NOW(a_full_word, rsp_valid && was_full, full_ok, "full insert word malformed")

endmodule

bind max_priority_queue_top mpq_checker u_mpq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .out_value   (rsp.out_value),
  .was_empty   (rsp.was_empty),
  .was_full    (rsp.was_full),
  .entry_count (rsp.entry_count)
);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      empty;
    logic                      full;
    logic [ENTRY_W-1:0]        count;
  } rsp_word_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic                      typed;
    rsp_word_t                 want;
  } stim_row_t;

  localparam logic signed [VALUE_W-1:0] VALUE_NONE = -1;
  localparam rsp_word_t NO_WANT = '0;
  localparam int RANDOM_WORDS = 430;
  localparam int LONG_HOLDOFF = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ROWS = 24;

  localparam stim_row_t DIRECTED [ROWS] = '{
    '{OP_POLL,   32'shdeadbeef, 16'sh1234, 1'b1, '{VALUE_NONE, 1'b1, 1'b0, 5'd0}},
    '{OP_INSERT, 32'sh7fffffff, 16'sh7fff, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh80000000, 16'sh8000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000000, 16'sh0000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000011, 16'sh0000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000012, 16'sh0000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000013, 16'sh0000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000021, 16'shffff, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000022, 16'sh0001, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000023, 16'sh7fff, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000024, 16'sh8000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh55555555, 16'sh5555, 1'b0, NO_WANT},
    '{OP_INSERT, 32'shaaaaaaaa, 16'shaaaa, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000031, 16'sh0000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000032, 16'sh0001, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000033, 16'sh7ffe, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh00000034, 16'sh8001, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh12345678, 16'sh0064, 1'b1, '{VALUE_NONE, 1'b0, 1'b1, 5'd16}},
    '{OP_POLL,   32'sh00000000, 16'sh0000, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0, 5'd15}},
    '{OP_POLL,   32'shffffffff, 16'shffff, 1'b0, NO_WANT},
    '{OP_POLL,   32'sh00000000, 16'sh0000, 1'b0, NO_WANT},
    '{OP_INSERT, 32'sh0f0f0f0f, 16'sh0000, 1'b0, NO_WANT},
    '{OP_POLL,   32'sh00000000, 16'sh0000, 1'b0, NO_WANT},
    '{OP_POLL,   32'sh00000000, 16'sh0000, 1'b0, NO_WANT}
  };

  logic clk;
  logic rst;

  mpq_req_if req_ch ();
  mpq_rsp_if rsp_ch ();

  max_priority_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [VALUE_W-1:0] shadow_value [DEPTH];
  logic signed [PRIO_W-1:0]  shadow_prio [DEPTH];
  int                        shadow_count;
  rsp_word_t                 pending_results [$];

  logic      row_typed;
  rsp_word_t row_want;
  logic      holdoff_request;

  int error_count;
  int idle_cycles;
  int insert_total;
  int full_rejects;
  int poll_total;
  int empty_polls;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_word_t apply_to_shadow(op_t op, logic signed [VALUE_W-1:0] value,
                                                logic signed [PRIO_W-1:0] prio);
    rsp_word_t res;
    int pos;
    res = '{VALUE_NONE, 1'b0, 1'b0, '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.full = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = value;
        shadow_prio[pos]  = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.empty = 1'b1;
      end else begin
        res.value = shadow_value[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_value[i-1] = shadow_value[i];
          shadow_prio[i-1]  = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    res.count = ENTRY_W'(shadow_count);
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    rsp_word_t predicted;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.out_value, rsp_ch.was_empty, rsp_ch.was_full, rsp_ch.entry_count};
        if (pending_results.size() == 0) begin
          $error("response word arrived with no operation outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, got.value);
            error_count++;
          end
          if (got.empty !== want.empty) begin
            $error("was_empty: expected %0b, got %0b", want.empty, got.empty);
            error_count++;
          end
          if (got.full !== want.full) begin
            $error("was_full: expected %0b, got %0b", want.full, got.full);
            error_count++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            error_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_to_shadow(req_ch.opcode, req_ch.item_value, req_ch.item_priority);
        if (req_ch.opcode == OP_INSERT) begin
          insert_total++;
          if (predicted.full) full_rejects++;
        end else begin
          poll_total++;
          if (predicted.empty) empty_polls++;
        end
        pending_results.push_back(row_typed ? row_want : predicted);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without a word moving, %0d responses outstanding",
                 idle_cycles, pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int   stretch;
    int   mode;
    int   hold_left;
    logic hold_done;
    stretch = 0;
    mode = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holdoff_request && !hold_done) begin
        hold_left = LONG_HOLDOFF;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(10, 60);
          mode = $urandom_range(0, 3);
        end
        stretch--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
          default: rsp_ch.ready <= stretch[0];
        endcase
      end
      @(negedge clk);
    end
  end

  task automatic offer_word(op_t op, logic signed [VALUE_W-1:0] value,
                            logic signed [PRIO_W-1:0] prio, logic typed, rsp_word_t want);
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.item_value    <= value;
    req_ch.item_priority <= prio;
    row_typed            <= typed;
    row_want             <= want;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
  endtask

  initial begin
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    int                        ins_pct;
    int                        segment_left;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_INSERT;
    req_ch.item_value = '0;
    req_ch.item_priority = '0;
    row_typed = 1'b0;
    row_want = NO_WANT;
    holdoff_request = 1'b0;
    shadow_count = 0;
    error_count = 0;
    idle_cycles = 0;
    insert_total = 0;
    full_rejects = 0;
    poll_total = 0;
    empty_polls = 0;
    burst_left = 0;
    ins_pct = 50;
    segment_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < ROWS; r++) begin
      offer_word(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].prio,
                 DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: ins_pct = 80;
          1: ins_pct = 50;
          default: ins_pct = 20;
        endcase
      end
      segment_left--;
      if (n == 100) holdoff_request <= 1'b1;
      if (n == 250) begin
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end else begin
        sender_gap();
      end
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POLL;
      value = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        prio = PRIO_W'($urandom);
      end else begin
        prio = PRIO_W'($urandom_range(0, 4)) - PRIO_W'(2);
      end
      offer_word(op, value, prio, 1'b0, NO_WANT);
    end

    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d inserts (%0d rejected on a full queue) and %0d polls (%0d on an empty one).",
             insert_total, full_rejects, poll_total, empty_polls);
    $display("Both channels idled at random, with one long response stall and one full drain.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mpq_pkg.sv
rtl/core/mpq_if.sv
rtl/core/mpq_cell.sv
rtl/core/max_priority_queue_top.sv
rtl/core/mpq_checker.sv
test/testbench.sv
